FILE: sv/pee_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// Holds character codes, state machine encodings and the command/status structs.
// No dependencies; pee_alu, pee_datapath, pee_ctrl and the top level import it.
package pee_pkg;

    localparam int DATA_W = 32;
    localparam int CHAR_W = 8;
    localparam int CCNT_W = 7;

    localparam logic [CHAR_W-1:0] CH_END  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] OP_ADD  = 8'h2B;
    localparam logic [CHAR_W-1:0] OP_SUB  = 8'h2D;
    localparam logic [CHAR_W-1:0] OP_MUL  = 8'h2A;
    localparam logic [CHAR_W-1:0] OP_DIV  = 8'h2F;
    localparam logic [CHAR_W-1:0] OP_POW  = 8'h5E;
    localparam logic [CHAR_W-1:0] OP_MOD  = 8'h25;

    typedef enum logic [2:0] {
        C_IDLE,
        C_POPX,
        C_POPY,
        C_CALC,
        C_WAIT,
        C_FPOP,
        C_FOUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_DIV,
        A_DFIX,
        A_PMUL,
        A_PSQR,
        A_DONE
    } alu_state_t;

    typedef struct packed {
        logic push_digit;
        logic latch_op;
        logic pop;
        logic capture_x;
        logic start_alu;
        logic push_result;
        logic load_out;
        logic clear_expr;
    } pee_cmd_t;

    typedef struct packed {
        logic alu_done;
        logic out_valid;
    } pee_sts_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

FILE: sv/pee_if.sv
// Handshake channel interfaces for the postfix expression evaluator.
// pee_char_if carries input characters, pee_result_if carries results.
// No dependencies.
interface pee_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface pee_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               div_zero_seen;

    modport source (output valid, output result_value, output div_zero_seen, input ready);
    modport sink   (input valid, input result_value, input div_zero_seen, output ready);
endinterface

FILE: sv/pee_alu.sv
// Multi-cycle arithmetic unit: add, subtract, multiply in one step, restoring
// division over 32 steps, and square-and-multiply power on one shared multiplier.
// Depends on pee_pkg.
module pee_alu (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [7:0]                  op,
    input  logic [31:0]                 y,
    input  logic [31:0]                 x,
    output logic                        done,
    output logic [31:0]                 result,
    output logic                        div_zero
);
    import pee_pkg::*;

    alu_state_t  state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] res_reg, res_next;
    logic        dz_reg, dz_next;
    logic        quot_reg, quot_next;
    logic        neg_reg, neg_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] product;
    logic [32:0] diff;
    logic [31:0] y_mag;
    logic [31:0] x_mag;

    assign product = mul_a * mul_b;
    assign diff    = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
    assign y_mag   = y[31] ? (32'd0 - y) : y;
    assign x_mag   = x[31] ? (32'd0 - x) : x;

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        dz_next    = dz_reg;
        quot_next  = quot_reg;
        neg_next   = neg_reg;
        mul_a      = y;
        mul_b      = x;
        done       = 1'b0;

        unique case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    dz_next    = 1'b0;
                    state_next = A_DONE;
                    case (op) inside
                        OP_ADD: res_next = y + x;
                        OP_SUB: res_next = y - x;
                        OP_MUL: res_next = product;
                        OP_DIV, OP_MOD:
                        begin
                            if (x == 32'd0)
                            begin
                                res_next = 32'd0;
                                dz_next  = 1'b1;
                            end
                            else
                            begin
                                quo_next   = y_mag;
                                rem_next   = 32'd0;
                                dvs_next   = x_mag;
                                cnt_next   = 5'd0;
                                quot_next  = (op == OP_DIV);
                                // Quotient sign differs from dividend sign only for '/'.
                                neg_next   = (op == OP_DIV) ? (y[31] ^ x[31]) : y[31];
                                state_next = A_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (x[31] || (x == 32'd0))
                            begin
                                res_next = 32'd1;
                            end
                            else
                            begin
                                acc_next   = 32'd1;
                                base_next  = y;
                                exp_next   = x;
                                state_next = A_PMUL;
                            end
                        end
                        default: res_next = 32'd0;
                    endcase
                end
            end
            A_DIV:
            begin
                if (!diff[32])
                begin
                    rem_next = diff[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (&cnt_reg)
                begin
                    state_next = A_DFIX;
                end
            end
            A_DFIX:
            begin
                if (quot_reg)
                begin
                    res_next = neg_reg ? (32'd0 - quo_reg) : quo_reg;
                end
                else
                begin
                    res_next = neg_reg ? (32'd0 - rem_reg) : rem_reg;
                end
                state_next = A_DONE;
            end
            A_PMUL:
            begin
                if (exp_reg == 32'd1)
                begin
                    mul_a      = acc_reg;
                    mul_b      = base_reg;
                    res_next   = product;
                    state_next = A_DONE;
                end
                else if (exp_reg[0])
                begin
                    mul_a      = acc_reg;
                    mul_b      = base_reg;
                    acc_next   = product;
                    state_next = A_PSQR;
                end
                else
                begin
                    mul_a     = base_reg;
                    mul_b     = base_reg;
                    base_next = product;
                    exp_next  = {1'b0, exp_reg[31:1]};
                end
            end
            A_PSQR:
            begin
                mul_a      = base_reg;
                mul_b      = base_reg;
                base_next  = product;
                exp_next   = {1'b0, exp_reg[31:1]};
                state_next = A_PMUL;
            end
            A_DONE:
            begin
                done       = 1'b1;
                state_next = A_IDLE;
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        dz_reg   <= dz_next;
        quot_reg <= quot_next;
        neg_reg  <= neg_next;
    end

    assign result   = res_reg;
    assign div_zero = dz_reg;

endmodule

FILE: sv/pee_datapath.sv
// Datapath of the postfix expression evaluator: operand stack memory, stack
// count, operand registers, arithmetic unit, divide-by-zero flag and result register.
// Depends on pee_pkg and pee_alu.
module pee_datapath #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          char_code,
    input  pee_pkg::pee_cmd_t   cmd,
    output logic                alu_done,
    output logic signed [31:0]  result_value,
    output logic                div_zero_seen
);
    import pee_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [31:0]   stack_mem [STACK_DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] count_dec;
    logic [31:0]   rd_reg;
    logic          empty_reg;
    logic [31:0]   x_reg;
    logic [7:0]    op_reg;
    logic          dz_flag_reg, dz_flag_next;
    logic signed [31:0] result_reg;
    logic          dz_out_reg;

    logic          not_empty;
    logic          not_full;
    logic          push_en;
    logic [31:0]   push_val;
    logic [31:0]   pop_val;
    logic [7:0]    digit_val;
    logic [31:0]   alu_result;
    logic          alu_dz;

    assign count_dec = count_reg - CW'(1);
    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg < CW'(STACK_DEPTH));
    assign digit_val = char_code - CH_ZERO;
    assign push_en   = (cmd.push_digit || cmd.push_result) && not_full;
    assign push_val  = cmd.push_digit ? {24'd0, digit_val} : alu_result;
    // A pop from an empty stack reads as zero.
    assign pop_val   = empty_reg ? 32'd0 : rd_reg;

    pee_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_alu),
        .op       (op_reg),
        .y        (pop_val),
        .x        (x_reg),
        .done     (alu_done),
        .result   (alu_result),
        .div_zero (alu_dz)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_expr)
        begin
            count_next = '0;
        end
        else if (push_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop && not_empty)
        begin
            count_next = count_dec;
        end
    end

    always_comb
    begin
        dz_flag_next = dz_flag_reg;
        if (cmd.clear_expr)
        begin
            dz_flag_next = 1'b0;
        end
        else if (alu_done && alu_dz)
        begin
            dz_flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dz_flag_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dz_flag_reg <= dz_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[count_reg[AW-1:0]] <= push_val;
        end
        if (cmd.pop && not_empty)
        begin
            rd_reg <= stack_mem[count_dec[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            empty_reg <= !not_empty;
        end
        if (cmd.capture_x)
        begin
            x_reg <= pop_val;
        end
        if (cmd.latch_op)
        begin
            op_reg <= char_code;
        end
        if (cmd.load_out)
        begin
            result_reg <= pop_val;
            dz_out_reg <= dz_flag_reg;
        end
    end

    assign result_value  = result_reg;
    assign div_zero_seen = dz_out_reg;

endmodule

FILE: sv/pee_ctrl.sv
// Controller of the postfix expression evaluator: sequences digit pushes,
// operator pops and evaluation, and the end-of-expression result transfer.
// Depends on pee_pkg.
module pee_ctrl #(
    parameter int MAX_CHARS = 80
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          char_code,
    input  logic                out_ready,
    input  pee_pkg::pee_sts_t   sts,
    output pee_pkg::pee_cmd_t   cmd,
    output logic                out_valid
);
    import pee_pkg::*;

    localparam logic [CCNT_W-1:0] MAX_CNT = CCNT_W'(MAX_CHARS);

    ctrl_state_t       state_reg, state_next;
    logic [CCNT_W-1:0] ccnt_reg, ccnt_next;
    logic              fin_reg, fin_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic [CCNT_W-1:0] ccnt_inc;
    logic              limit_hit;

    assign ccnt_inc  = ccnt_reg + CCNT_W'(1);
    assign limit_hit = (ccnt_inc >= MAX_CNT);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        ccnt_next  = ccnt_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            C_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (char_code == CH_END)
                    begin
                        state_next = C_FPOP;
                    end
                    else if (is_digit(char_code))
                    begin
                        cmd.push_digit = 1'b1;
                        ccnt_next      = ccnt_inc;
                        if (limit_hit)
                        begin
                            state_next = C_FPOP;
                        end
                    end
                    else
                    begin
                        cmd.latch_op = 1'b1;
                        ccnt_next    = ccnt_inc;
                        fin_next     = limit_hit;
                        state_next   = C_POPX;
                    end
                end
            end
            C_POPX:
            begin
                cmd.pop    = 1'b1;
                state_next = C_POPY;
            end
            C_POPY:
            begin
                cmd.capture_x = 1'b1;
                cmd.pop       = 1'b1;
                state_next    = C_CALC;
            end
            C_CALC:
            begin
                cmd.start_alu = 1'b1;
                state_next    = C_WAIT;
            end
            C_WAIT:
            begin
                if (sts.alu_done)
                begin
                    cmd.push_result = 1'b1;
                    state_next      = fin_reg ? C_FPOP : C_IDLE;
                end
            end
            C_FPOP:
            begin
                cmd.pop    = 1'b1;
                state_next = C_FOUT;
            end
            C_FOUT:
            begin
                if (!sts.out_valid || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.clear_expr = 1'b1;
                    ccnt_next      = '0;
                    fin_next       = 1'b0;
                    state_next     = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            ccnt_reg      <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ccnt_reg      <= ccnt_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/postfix_expression_evaluator.sv
// Postfix expression evaluator, top level: a controller and a datapath.
// Depends on pee_pkg, pee_if, pee_ctrl, pee_datapath and pee_alu.
//
// Usage: characters of a postfix expression arrive one per transfer on char_ch.
// A digit pushes its value; any other nonzero byte pops two operands and pushes
// the result of + - * / ^ % (unknown operators push 0). A zero byte, or the
// MAX_CHARS-th character, ends the expression: the top of the stack and the
// divide-by-zero flag then leave as one transfer on result_ch.
// Sequence: a digit is pushed as it is accepted. An operator passes the states
// POPX, POPY, CALC and WAIT; + - *, unknown codes, a zero divisor and an
// exponent below one go straight to the arithmetic unit's done state. / and %
// with a nonzero divisor run the 32-step restoring divider; ^ runs on the single
// multiplier that alternates between multiply and square. Ending an expression
// passes the FPOP and FOUT states before the result register loads.
// The result register sits between the two sides: the block keeps taking
// characters while a result waits; it only holds at the next expression end
// until the receiver has taken the earlier result.
// Reset clears the stack count, character count, flag and pending output;
// stack contents need no clearing since entries above the count are never read.
module postfix_expression_evaluator #(
    parameter int MAX_CHARS   = 80,
    parameter int STACK_DEPTH = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    pee_char_if.sink          char_ch,
    pee_result_if.source      result_ch
);
    import pee_pkg::*;

    pee_cmd_t cmd;
    pee_sts_t sts;
    logic     alu_done;
    logic     out_valid;

    // Status from the datapath and the output register state go back to the
    // controller together.
    assign sts.alu_done  = alu_done;
    assign sts.out_valid = out_valid;

    pee_ctrl #(
        .MAX_CHARS (MAX_CHARS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (char_ch.valid),
        .in_ready  (char_ch.ready),
        .char_code (char_ch.char_code),
        .out_ready (result_ch.ready),
        .sts       (sts),
        .cmd       (cmd),
        .out_valid (out_valid)
    );

    pee_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_code     (char_ch.char_code),
        .cmd           (cmd),
        .alu_done      (alu_done),
        .result_value  (result_ch.result_value),
        .div_zero_seen (result_ch.div_zero_seen)
    );

    assign result_ch.valid = out_valid;

endmodule
